@@ hw/rtl/exl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exl_pkg: shared types and constants of the expression lexer
// Word formats for the input, queue and result sides, token kinds,
// character classes and error codes.
// ----------------------------------------------------------------------------
package exl_pkg;

    // Input word: one character or an end marker
    typedef struct packed {
        logic       action;
        logic [7:0] char_code;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [7:0] echo_char;
        logic [2:0] token_kind;
        logic       starts_token;
        logic       was_space;
        logic [3:0] error_code;
        logic       expr_done;
        logic [7:0] depth_now;
    } t_out_word;

    // Character classes found by the front end
    localparam logic [3:0] C_OTHER     = 4'd0;
    localparam logic [3:0] C_DIGIT     = 4'd1;
    localparam logic [3:0] C_DOT       = 4'd2;
    localparam logic [3:0] C_LETTER    = 4'd3;
    localparam logic [3:0] C_PLUSMINUS = 4'd4;
    localparam logic [3:0] C_MULDIV    = 4'd5;
    localparam logic [3:0] C_OPEN      = 4'd6;
    localparam logic [3:0] C_CLOSE     = 4'd7;
    localparam logic [3:0] C_SPACE     = 4'd8;

    // Classified word travelling from front end to back end
    typedef struct packed {
        logic       action;
        logic [3:0] char_class;
        logic [7:0] char_code;
    } t_cls_word;

    // Token kinds
    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_NUM   = 3'd1;
    localparam logic [2:0] K_ID    = 3'd2;
    localparam logic [2:0] K_BIN   = 3'd3;
    localparam logic [2:0] K_UN    = 3'd4;
    localparam logic [2:0] K_OPEN  = 3'd5;
    localparam logic [2:0] K_CLOSE = 3'd6;

    // Error codes
    localparam logic [3:0] E_NONE            = 4'd0;
    localparam logic [3:0] E_BAD_START       = 4'd1;
    localparam logic [3:0] E_NO_OPEN         = 4'd2;
    localparam logic [3:0] E_BAD_NUMBER      = 4'd3;
    localparam logic [3:0] E_BAD_IDENT       = 4'd4;
    localparam logic [3:0] E_NO_OPERAND      = 4'd5;
    localparam logic [3:0] E_NO_UNARY_OPND   = 4'd6;
    localparam logic [3:0] E_BAD_AFTER_OPEN  = 4'd7;
    localparam logic [3:0] E_BAD_AFTER_CLOSE = 4'd8;
    localparam logic [3:0] E_NO_CLOSE        = 4'd9;
    localparam logic [3:0] E_TRAILING_OP     = 4'd10;
    localparam logic [3:0] E_INTERNAL        = 4'd11;

    // Queue between front end and back end
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

endpackage

@@ hw/rtl/exl_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exl_front: character classifier
// Accepts input words, sorts each character into a class and holds the
// classified word in a register until the queue takes it.
// ----------------------------------------------------------------------------
module exl_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  exl_pkg::t_in_word  i_in_word,
    output logic               o_q_push,
    input  logic               i_q_full,
    output exl_pkg::t_cls_word o_q_word
);
    import exl_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_cls_word r_word;
    t_cls_word n_word;
    logic      accept;

    function automatic logic [3:0] classify(input logic [7:0] c);
        logic [3:0] cls;
        cls = C_OTHER;
        if (c >= "0" && c <= "9") begin
            cls = C_DIGIT;
        end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
            cls = C_LETTER;
        end else begin
            case (c)
                ".":     cls = C_DOT;
                "+":     cls = C_PLUSMINUS;
                "-":     cls = C_PLUSMINUS;
                "*":     cls = C_MULDIV;
                "/":     cls = C_MULDIV;
                "^":     cls = C_MULDIV;
                "(":     cls = C_OPEN;
                ")":     cls = C_CLOSE;
                " ":     cls = C_SPACE;
                default: cls = C_OTHER;
            endcase
        end
        return cls;
    endfunction

    assign o_q_push = r_valid && !i_q_full;
    assign o_full   = r_valid && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_word = r_word;

    always_comb begin
        n_word            = r_word;
        n_valid           = r_valid;
        if (accept) begin
            n_word.action     = i_in_word.action;
            n_word.char_class = classify(i_in_word.char_code);
            n_word.char_code  = i_in_word.char_code;
            n_valid           = 1'b1;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

@@ hw/rtl/exl_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exl_queue: classified-word queue
// Small first-in first-out store that decouples the classifier from the
// grammar engine.
// ----------------------------------------------------------------------------
module exl_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  exl_pkg::t_cls_word i_word,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output exl_pkg::t_cls_word o_word
);
    import exl_pkg::*;

    t_cls_word           r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW:0]   r_wr_ptr;
    logic [QUEUE_AW:0]   r_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[QUEUE_AW] != r_rd_ptr[QUEUE_AW]) &&
                     (r_wr_ptr[QUEUE_AW-1:0] == r_rd_ptr[QUEUE_AW-1:0]);
    assign o_word  = r_mem[r_rd_ptr[QUEUE_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr[QUEUE_AW-1:0]] <= i_word;
        end
    end

endmodule

@@ hw/rtl/exl_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exl_back: grammar engine
// Applies the token grammar to classified words, keeps token kind, bracket
// depth and latched error, and holds each result in an output register.
// ----------------------------------------------------------------------------
module exl_back #(
    parameter int MAX_DEPTH = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  exl_pkg::t_cls_word i_q_word,
    output logic               o_q_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output exl_pkg::t_out_word o_out_word
);
    import exl_pkg::*;

    localparam logic [7:0] DEPTH_LIMIT = (MAX_DEPTH < 255) ? 8'(MAX_DEPTH) : 8'd255;

    logic [2:0] r_cur;
    logic [2:0] n_cur;
    logic [7:0] r_depth;
    logic [7:0] n_depth;
    logic [3:0] r_err;
    logic [3:0] n_err;
    logic       r_out_valid;
    t_out_word  r_out;
    t_out_word  n_out;
    logic       take;

    assign take       = !i_q_empty && (!r_out_valid || i_pop);
    assign o_q_pop    = take;
    assign o_empty    = !r_out_valid;
    assign o_out_word = r_out;

    always_comb begin
        logic [2:0] next;
        logic [3:0] fail;
        logic [3:0] cls;
        next    = K_NONE;
        fail    = E_NONE;
        cls     = i_q_word.char_class;
        n_cur   = r_cur;
        n_depth = r_depth;
        n_err   = r_err;

        n_out              = '0;
        n_out.echo_char    = i_q_word.char_code;

        if (i_q_word.action) begin
            // end marker: final checks, then back to reset state
            n_out.echo_char = 8'd0;
            n_out.expr_done = 1'b1;
            n_out.error_code = r_err;
            if (r_err == E_NONE && r_cur != K_NONE) begin
                if (r_depth != 8'd0) begin
                    n_out.error_code = E_NO_CLOSE;
                end
                if (r_cur == K_UN || r_cur == K_BIN) begin
                    n_out.error_code = E_TRAILING_OP;
                end
            end
            n_cur   = K_NONE;
            n_depth = 8'd0;
            n_err   = E_NONE;
        end else if (r_err != E_NONE) begin
            // drop characters until the end marker
            n_out.error_code = r_err;
        end else if (cls == C_SPACE && r_cur <= K_CLOSE) begin
            n_out.was_space  = 1'b1;
            n_out.token_kind = r_cur;
        end else begin
            case (r_cur)
                K_NONE, K_BIN, K_UN, K_OPEN: begin
                    // operand position
                    case (cls)
                        C_DIGIT:     next = K_NUM;
                        C_LETTER:    next = K_ID;
                        C_PLUSMINUS: next = K_UN;
                        C_OPEN: begin
                            if (r_depth >= DEPTH_LIMIT) begin
                                fail = E_INTERNAL;
                            end else begin
                                n_depth = r_depth + 8'd1;
                                next    = K_OPEN;
                            end
                        end
                        default:     next = K_NONE;
                    endcase
                    if (next == K_NONE && fail == E_NONE) begin
                        case (r_cur)
                            K_NONE:  fail = E_BAD_START;
                            K_BIN:   fail = E_NO_OPERAND;
                            K_UN:    fail = E_NO_UNARY_OPND;
                            default: fail = E_BAD_AFTER_OPEN;
                        endcase
                    end
                end
                K_NUM, K_ID, K_CLOSE: begin
                    if (r_cur == K_NUM && (cls == C_DIGIT || cls == C_DOT)) begin
                        n_out.token_kind = K_NUM;
                    end else if (r_cur == K_ID && (cls == C_LETTER || cls == C_DIGIT)) begin
                        n_out.token_kind = K_ID;
                    end else begin
                        // operator position
                        case (cls)
                            C_PLUSMINUS, C_MULDIV: next = K_BIN;
                            C_CLOSE: begin
                                if (r_depth == 8'd0) begin
                                    fail = E_NO_OPEN;
                                end else begin
                                    n_depth = r_depth - 8'd1;
                                    next    = K_CLOSE;
                                end
                            end
                            default: next = K_NONE;
                        endcase
                        if (next == K_NONE && fail == E_NONE) begin
                            case (r_cur)
                                K_NUM:   fail = E_BAD_NUMBER;
                                K_ID:    fail = E_BAD_IDENT;
                                default: fail = E_BAD_AFTER_CLOSE;
                            endcase
                        end
                    end
                end
                default: fail = E_INTERNAL;
            endcase

            if (fail != E_NONE) begin
                n_err            = fail;
                n_out.error_code = fail;
                n_out.token_kind = K_NONE;
            end else if (next != K_NONE) begin
                n_cur              = next;
                n_out.token_kind   = next;
                n_out.starts_token = 1'b1;
            end
        end
        n_out.depth_now = n_depth;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= K_NONE;
            r_depth     <= 8'd0;
            r_err       <= E_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_cur   <= n_cur;
                r_depth <= n_depth;
                r_err   <= n_err;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

endmodule

@@ hw/rtl/expression_lexer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_lexer_core: arithmetic expression tokenizer
// One character per word in, one classification result per word out.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive i_in_word and raise push; the word is taken on an edge
//   where full is low. action = 1 marks the end of an expression.
//   Result queue: while empty is low, o_out_word holds the oldest result;
//   raise pop to take it. Every input word yields exactly one result word.
//   Path: a taken word passes the classifier register, then the queue, then
//   the grammar engine output register, and then shows on o_out_word.
//   Throughput: one word per cycle, sustained while pop keeps up; the grammar
//   engine updates its token kind, depth and error state once per word.
//   Stall: when pop stays low, the output register holds its word, the
//   four-deep queue fills, then the classifier register, and full rises.
//   Reset (synchronous, active low): all queues empty, token kind start,
//   bracket depth zero, no error latched.
//   An opening bracket at depth min(MAX_DEPTH, 255) reports the internal
//   error code.
// ----------------------------------------------------------------------------
module expression_lexer_core #(
    parameter int MAX_DEPTH = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  exl_pkg::t_in_word  i_in_word,
    output logic               empty,
    input  logic               pop,
    output exl_pkg::t_out_word o_out_word
);
    import exl_pkg::*;

    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;
    t_cls_word q_in_word;
    t_cls_word q_out_word;

    // Classify each character and hold it for the queue
    exl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_in_word (i_in_word),
        .o_q_push  (q_push),
        .i_q_full  (q_full),
        .o_q_word  (q_in_word)
    );

    // Decouple classifier and grammar engine
    exl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (q_in_word),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_word  (q_out_word)
    );

    // Advance the grammar state and register each result
    exl_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_word   (q_out_word),
        .o_q_pop    (q_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_word (o_out_word)
    );

    // Result queue is empty the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present after reset");

    // End results carry no character and leave depth at zero
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_word.expr_done) |->
            (o_out_word.depth_now == 8'd0 && o_out_word.echo_char == 8'd0 &&
             !o_out_word.starts_token && !o_out_word.was_space))
        else $error("end result not clean");

    // A new token always names a kind and never reports an error
    a_start_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_word.starts_token) |->
            (o_out_word.token_kind != K_NONE && o_out_word.error_code == E_NONE))
        else $error("token start without kind");

    // A skipped space carries no error and starts nothing
    a_space_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_word.was_space) |->
            (o_out_word.error_code == E_NONE && !o_out_word.starts_token))
        else $error("space result with error or start");

endmodule
